// File: design/bdq_pkg.sv
// Shared constants, codes and types for the bounded deque.
// No dependencies; imported by every module of the block.

package bdq_pkg;

  localparam int DEPTH      = 512;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = 10;
  localparam int LIM_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int CAP_RESET  = 512;

  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_PUSH_TOP = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP_TOP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_BOT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BOT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ROT      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REV_ROT  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd6;

  localparam int STS_W = 2;
  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_OVERFLOW  = 2'd1;
  localparam logic [STS_W-1:0] STS_UNDERFLOW = 2'd2;

  localparam logic [1:0] SH_HOLD = 2'd0;
  localparam logic [1:0] SH_FWD  = 2'd1;
  localparam logic [1:0] SH_BACK = 2'd2;

  typedef struct packed {
    logic [1:0]       shift;
    logic             ins_en;
    logic [IDX_W-1:0] ins_pos;
  } chain_ctl_t;

endpackage

// File: design/bounded_deque_with_rotate.sv
// Top level of the bounded deque: command decode, count, limit register, result.
// Depends on bdq_pkg and bdq_chain.
//
// Use: a request is taken when start is high and busy is low. It carries a
// command and a push value. Its result (status, popped value, element count)
// is shown for exactly one cycle with out_valid high, the cycle after the
// request is taken.
// Throughput: one request per cycle while busy is low. Both ends of the
// deque sit at fixed cells of two rows of DEPTH cells (one ordered from the
// top, one from the bottom), so a command updates the rows it needs at once.
// The user must write the capacity limit (cfg_valid/cfg_ready/cfg_capacity_limit)
// only while no request is in flight; the block itself does not enforce this.
// Reset (rst_n low, synchronous): count cleared, limit back to 512, stored
// words left undefined. busy and !cfg_ready are high during reset and drop at
// the first edge after it. The receiver cannot stall; results are never held.

module bounded_deque_with_rotate (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [bdq_pkg::CMD_W-1:0]             in_command,
  input  logic signed [bdq_pkg::DATA_WIDTH-1:0] in_push_value,
  output logic                                  out_valid,
  output logic [bdq_pkg::STS_W-1:0]             out_status,
  output logic signed [bdq_pkg::DATA_WIDTH-1:0] out_popped_value,
  output logic [bdq_pkg::CNT_W-1:0]             out_element_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bdq_pkg::CAP_W-1:0]             cfg_capacity_limit
);
  import bdq_pkg::*;

  logic                  busy_r;
  logic [CAP_W-1:0]      cap_r;
  logic [CAP_W-1:0]      cap_nxt;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic [STS_W-1:0]      status_r;
  logic [STS_W-1:0]      status_nxt;
  logic [DATA_WIDTH-1:0] popped_r;
  logic [DATA_WIDTH-1:0] popped_nxt;

  logic                  take;
  logic [LIM_W-1:0]      cap_ext;
  logic [LIM_W-1:0]      lim;
  logic                  full;
  logic                  empty;
  logic                  two_plus;
  logic [IDX_W-1:0]      pos_cnt;
  logic [IDX_W-1:0]      pos_last;

  chain_ctl_t            top_ctl;
  chain_ctl_t            bot_ctl;
  logic [DATA_WIDTH-1:0] top_val;
  logic [DATA_WIDTH-1:0] bot_val;
  logic [DATA_WIDTH-1:0] top_head;
  logic [DATA_WIDTH-1:0] bot_head;
  logic [DATA_WIDTH-1:0] push_v;

  assign take     = start && !busy_r;
  assign push_v   = in_push_value;
  assign cap_ext  = LIM_W'(cap_r);
  assign lim      = (cap_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : cap_ext;
  assign full     = LIM_W'(count_r) >= lim;
  assign empty    = (count_r == '0);
  assign two_plus = (count_r >= CNT_W'(2));
  assign pos_cnt  = count_r[IDX_W-1:0];
  assign pos_last = IDX_W'(count_r - CNT_W'(1));
  assign cap_nxt  = (cfg_valid && cfg_ready) ? cfg_capacity_limit : cap_r;

  always_comb begin
    top_ctl    = '{shift: SH_HOLD, ins_en: 1'b0, ins_pos: '0};
    bot_ctl    = '{shift: SH_HOLD, ins_en: 1'b0, ins_pos: '0};
    top_val    = push_v;
    bot_val    = push_v;
    count_nxt  = count_r;
    status_nxt = STS_OK;
    popped_nxt = '0;
    if (take) begin
      unique case (in_command)
        CMD_PUSH_TOP: begin
          if (full) begin
            status_nxt = STS_OVERFLOW;
          end else begin
            top_ctl.shift   = SH_FWD;
            bot_ctl.ins_en  = 1'b1;
            bot_ctl.ins_pos = pos_cnt;
            count_nxt       = count_r + CNT_W'(1);
          end
        end
        CMD_POP_TOP: begin
          if (empty) begin
            status_nxt = STS_UNDERFLOW;
          end else begin
            popped_nxt    = top_head;
            top_ctl.shift = SH_BACK;
            count_nxt     = count_r - CNT_W'(1);
          end
        end
        CMD_PUSH_BOT: begin
          if (full) begin
            status_nxt = STS_OVERFLOW;
          end else begin
            bot_ctl.shift   = SH_FWD;
            top_ctl.ins_en  = 1'b1;
            top_ctl.ins_pos = pos_cnt;
            count_nxt       = count_r + CNT_W'(1);
          end
        end
        CMD_POP_BOT: begin
          if (empty) begin
            status_nxt = STS_UNDERFLOW;
          end else begin
            popped_nxt    = bot_head;
            bot_ctl.shift = SH_BACK;
            count_nxt     = count_r - CNT_W'(1);
          end
        end
        CMD_ROT: begin
          if (two_plus) begin
            top_val         = top_head;
            bot_val         = top_head;
            top_ctl.shift   = SH_BACK;
            top_ctl.ins_en  = 1'b1;
            top_ctl.ins_pos = pos_last;
            bot_ctl.shift   = SH_FWD;
          end
        end
        CMD_REV_ROT: begin
          if (two_plus) begin
            top_val         = bot_head;
            bot_val         = bot_head;
            bot_ctl.shift   = SH_BACK;
            bot_ctl.ins_en  = 1'b1;
            bot_ctl.ins_pos = pos_last;
            top_ctl.shift   = SH_FWD;
          end
        end
        CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // top row: cell 0 is the top element; bottom row: cell 0 is the bottom one
  bdq_chain u_top_row (
    .clk  (clk),
    .ctl  (top_ctl),
    .val  (top_val),
    .head (top_head)
  );

  bdq_chain u_bot_row (
    .clk  (clk),
    .ctl  (bot_ctl),
    .val  (bot_val),
    .head (bot_head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      cap_r       <= CAP_W'(CAP_RESET);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      out_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    popped_r <= popped_nxt;
  end

  assign busy              = busy_r;
  assign cfg_ready         = !busy_r;
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_popped_value  = popped_r;
  assign out_element_count = count_r;

endmodule

// File: design/bdq_cell.sv
// One storage cell of a deque row: holds a word, loads from either neighbour
// or from the broadcast value. Depends on bdq_pkg.

module bdq_cell (
  input  logic                           clk,
  input  logic [bdq_pkg::IDX_W-1:0]      idx,
  input  bdq_pkg::chain_ctl_t            ctl,
  input  logic [bdq_pkg::DATA_WIDTH-1:0] val,
  input  logic [bdq_pkg::DATA_WIDTH-1:0] prev_d,
  input  logic [bdq_pkg::DATA_WIDTH-1:0] next_d,
  output logic [bdq_pkg::DATA_WIDTH-1:0] data
);
  import bdq_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins_en && (ctl.ins_pos == idx)) begin
      data_nxt = val;
    end else begin
      unique case (ctl.shift)
        SH_FWD:  data_nxt = prev_d;
        SH_BACK: data_nxt = next_d;
        default: data_nxt = data_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// File: design/bdq_chain.sv
// Row of DEPTH cells with a fixed head at cell 0; shifts, inserts at a position.
// Depends on bdq_pkg and bdq_cell.

module bdq_chain (
  input  logic                           clk,
  input  bdq_pkg::chain_ctl_t            ctl,
  input  logic [bdq_pkg::DATA_WIDTH-1:0] val,
  output logic [bdq_pkg::DATA_WIDTH-1:0] head
);
  import bdq_pkg::*;

  logic [DATA_WIDTH-1:0] row [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_d;
    logic [DATA_WIDTH-1:0] next_d;

    if (g == 0) begin : g_first
      assign prev_d = val;
    end else begin : g_mid_prev
      assign prev_d = row[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_d = val;
    end else begin : g_mid_next
      assign next_d = row[g+1];
    end

    bdq_cell u_cell (
      .clk    (clk),
      .idx    (IDX_W'(g)),
      .ctl    (ctl),
      .val    (val),
      .prev_d (prev_d),
      .next_d (next_d),
      .data   (row[g])
    );
  end

  assign head = row[0];

endmodule

// File: tb/tb_bounded_deque_with_rotate.sv
// Self-checking testbench for bounded_deque_with_rotate: directed corner cases, then
// random command streams under several capacity limits, checked against a queue model.
// Depends on bdq_pkg and the bounded_deque_with_rotate RTL.

module tb_bounded_deque_with_rotate;
  import bdq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  typedef struct packed {
    logic [STS_W-1:0]             status;
    logic signed [DATA_WIDTH-1:0] popped;
    logic [CNT_W-1:0]             count;
  } deque_reply_t;

  class deque_scoreboard;
    logic signed [DATA_WIDTH-1:0] held_words[$];
    logic [CAP_W-1:0]             limit;
    deque_reply_t                 awaited_replies[$];
    int unsigned                  mismatches;

    function new();
      limit = CAP_W'(CAP_RESET);
      mismatches = 0;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic signed [DATA_WIDTH-1:0] value);
      deque_reply_t                 r;
      int unsigned                  room;
      bit                           full;
      logic signed [DATA_WIDTH-1:0] w;
      room = (limit < DEPTH) ? limit : DEPTH;
      full = held_words.size() >= room;
      r.status = STS_OK;
      r.popped = '0;
      case (cmd)
        CMD_PUSH_TOP: begin
          if (full) r.status = STS_OVERFLOW;
          else held_words.push_front(value);
        end
        CMD_PUSH_BOT: begin
          if (full) r.status = STS_OVERFLOW;
          else held_words.push_back(value);
        end
        CMD_POP_TOP: begin
          if (held_words.size() == 0) r.status = STS_UNDERFLOW;
          else r.popped = held_words.pop_front();
        end
        CMD_POP_BOT: begin
          if (held_words.size() == 0) r.status = STS_UNDERFLOW;
          else r.popped = held_words.pop_back();
        end
        CMD_ROT: begin
          if (held_words.size() >= 2) begin
            w = held_words.pop_front();
            held_words.push_back(w);
          end
        end
        CMD_REV_ROT: begin
          if (held_words.size() >= 2) begin
            w = held_words.pop_back();
            held_words.push_front(w);
          end
        end
        CMD_CLEAR: held_words.delete();
        default: ;
      endcase
      r.count = CNT_W'(held_words.size());
      awaited_replies.push_back(r);
    endfunction

    function void check_reply(logic [STS_W-1:0] status, logic signed [DATA_WIDTH-1:0] popped,
                              logic [CNT_W-1:0] count);
      deque_reply_t want;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d popped %0d count %0d", status, popped, count);
      end else begin
        want = awaited_replies.pop_front();
        if (status !== want.status || popped !== want.popped || count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d popped %0d/%0d count %0d/%0d (exp/act)",
                     want.status, status, want.popped, popped, want.count, count);
        end
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [CMD_W-1:0]             in_command;
  logic signed [DATA_WIDTH-1:0] in_push_value;
  logic                         out_valid;
  logic [STS_W-1:0]             out_status;
  logic signed [DATA_WIDTH-1:0] out_popped_value;
  logic [CNT_W-1:0]             out_element_count;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CAP_W-1:0]             cfg_capacity_limit;

  deque_scoreboard sb;

  bounded_deque_with_rotate u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_push_value     (in_push_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_popped_value  (out_popped_value),
    .out_element_count (out_element_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_capacity_limit(cfg_capacity_limit)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_reply(out_status, out_popped_value, out_element_count);
      if (start && !busy) sb.note_request(in_command, in_push_value);
      if (cfg_valid && cfg_ready) sb.limit = cfg_capacity_limit;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send(logic [CMD_W-1:0] cmd, logic signed [DATA_WIDTH-1:0] value);
    start         <= 1'b1;
    in_command    <= cmd;
    in_push_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_off(int unsigned cycles);
    start         <= 1'b0;
    in_command    <= CMD_W'($urandom());
    in_push_value <= $urandom();
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.awaited_replies.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_limit(logic [CAP_W-1:0] value);
    drain();
    cfg_valid          <= 1'b1;
    cfg_capacity_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid          <= 1'b0;
    cfg_capacity_limit <= CAP_W'($urandom());
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(int unsigned push_pct);
    int unsigned r;
    if ($urandom_range(99) < push_pct) return $urandom_range(1) ? CMD_PUSH_TOP : CMD_PUSH_BOT;
    r = $urandom_range(99);
    // clears only where the queue is not meant to fill up
    if (push_pct >= 90 && r >= 94) r = r - 60;
    if (r < 30) return CMD_POP_TOP;
    if (r < 60) return CMD_POP_BOT;
    if (r < 77) return CMD_ROT;
    if (r < 94) return CMD_REV_ROT;
    if (r < 97) return CMD_CLEAR;
    return CMD_UNUSED;
  endfunction

  task automatic random_phase(logic [CAP_W-1:0] lim, int unsigned items,
                              int unsigned push_pct, int unsigned gap_pct);
    bit quiet;
    write_limit(lim);
    quiet = 1'b0;
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(2) == 0);
      send(pick_command(push_pct), pick_value());
      if (!quiet && gap_pct != 0 && $urandom_range(99) < gap_pct)
        hold_off($urandom_range(1, 3));
    end
  endtask

  initial begin
    sb                 = new();
    rst_n              = 1'b0;
    start              = 1'b0;
    in_command         = CMD_PUSH_TOP;
    in_push_value      = '0;
    cfg_valid          = 1'b0;
    cfg_capacity_limit = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // empty queue, single element, both ends, unused code, clear
    send(CMD_POP_TOP, 32'sh1234_5678);
    send(CMD_POP_BOT, -1);
    send(CMD_ROT, '0);
    send(CMD_REV_ROT, '0);
    send(CMD_PUSH_TOP, 32'sh7FFF_FFFF);
    send(CMD_ROT, '0);
    hold_off(2);
    send(CMD_REV_ROT, '0);
    send(CMD_PUSH_BOT, 32'sh8000_0000);
    send(CMD_PUSH_TOP, -1);
    send(CMD_PUSH_BOT, '0);
    send(CMD_ROT, '0);
    send(CMD_REV_ROT, '0);
    send(CMD_UNUSED, 32'sh5A5A_A5A5);
    send(CMD_POP_TOP, '0);
    send(CMD_POP_BOT, '0);
    send(CMD_CLEAR, '0);
    send(CMD_POP_BOT, '0);
    send(CMD_PUSH_TOP, 32'sd1);
    send(CMD_PUSH_BOT, 32'sd2);
    send(CMD_PUSH_TOP, 32'sd3);

    // limit lowered below the count
    write_limit(2);
    send(CMD_PUSH_BOT, 32'sd4);
    send(CMD_POP_TOP, '0);
    send(CMD_PUSH_TOP, 32'sd5);
    send(CMD_POP_BOT, '0);
    send(CMD_PUSH_TOP, 32'sd6);

    // limit of zero
    write_limit(0);
    send(CMD_PUSH_TOP, 32'sd7);
    send(CMD_POP_TOP, '0);
    send(CMD_PUSH_BOT, 32'sd8);
    send(CMD_POP_BOT, '0);

    random_phase(4, 150, 45, 25);
    random_phase(1023, 560, 96, 20);
    random_phase(512, 120, 40, 25);
    random_phase(0, 60, 30, 25);
    random_phase(1, 80, 45, 25);
    random_phase(37, 230, 50, 0);

    drain();
    if (sb.mismatches == 0 && sb.awaited_replies.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
